### hw/rtl/glos_pkg.sv
package glos_pkg;

    // item field widths
    localparam int unsigned COORD_W    = 9;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

    // bitmap word layout: column x is bit (x & 63) of word (x >> 6) of its row
    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned BIT_SEL_W = 6;

    // walk bookkeeping
    localparam int unsigned GUARD_W = COORD_W + 1;

    // defaults of the top level parameters
    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;
    localparam int unsigned ROW_WORDS_DEF  = 4;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_CUT   = 2'd2;
    localparam logic [COORD_W-1:0]     GRID_SIZE_RESET  = 9'd256;

    // command codes (carried on s_tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic start;
        logic release_ack;
    } walk_ctl_t;

    typedef struct packed {
        logic done;
        logic sight;
    } walk_stat_t;

    function automatic logic coord_inside(coord_t c, coord_t lim, int unsigned max_lim);
        return (32'(c) < 32'(lim)) && (32'(c) < max_lim);
    endfunction

    function automatic logic cell_in_row(coord_t x, int unsigned row_words);
        return 32'(x[COORD_W-1:BIT_SEL_W]) < row_words;
    endfunction

    function automatic logic [31:0] word_index(coord_t x, coord_t y, int unsigned row_words);
        return 32'(y) * row_words + 32'(x[COORD_W-1:BIT_SEL_W]);
    endfunction

endpackage

### hw/rtl/glos_store.sv
module glos_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  glos_pkg::word_t     wr_data,
    input  logic [AW-1:0]       rd_addr,
    output glos_pkg::word_t     rd_word
);

    glos_pkg::word_t mem [DEPTH];
    glos_pkg::word_t rd_word_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_word = rd_word_reg;

endmodule

### hw/rtl/glos_walk.sv
module glos_walk #(
    parameter int unsigned MAX_WIDTH  = glos_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = glos_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned ROW_WORDS  = glos_pkg::ROW_WORDS_DEF,
    parameter int unsigned AW         = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  glos_pkg::walk_ctl_t   ctl,
    input  glos_pkg::coord_t      x_from,
    input  glos_pkg::coord_t      y_from,
    input  glos_pkg::coord_t      x_to,
    input  glos_pkg::coord_t      y_to,
    input  glos_pkg::coord_t      grid_width,
    input  glos_pkg::coord_t      grid_height,
    input  logic                  corner_cut,
    output logic [AW-1:0]         rd_addr,
    input  glos_pkg::word_t       rd_word,
    output glos_pkg::walk_stat_t  stat
);

    localparam int unsigned DW = glos_pkg::COORD_W + 3;
    localparam int unsigned GW = glos_pkg::GUARD_W;

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_RUN  = 2'd1;
    localparam logic [1:0] W_DONE = 2'd2;

    // diagonal step without corner cutting: two corner reads, then the move
    localparam logic [1:0] PH_CORNER_A = 2'd0;
    localparam logic [1:0] PH_CORNER_B = 2'd1;
    localparam logic [1:0] PH_MOVE     = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [1:0]                        phase_reg, phase_next;
    glos_pkg::coord_t                  x_reg, x_next, y_reg, y_next;
    glos_pkg::coord_t                  nx_reg, nx_next, ny_reg, ny_next;
    glos_pkg::coord_t                  ix_reg, ix_next, iy_reg, iy_next;
    logic                              x_dec_reg, x_dec_next, y_dec_reg, y_dec_next;
    logic signed [DW-1:0]              d_reg, d_next;
    logic [GW-1:0]                     guard_reg, guard_next;
    logic                              started_reg, started_next;
    logic                              pend_reg, pend_next;
    logic                              cell_ok_reg, cell_ok_next;
    logic [glos_pkg::BIT_SEL_W-1:0]    bit_sel_reg, bit_sel_next;
    logic                              sight_reg, sight_next;

    glos_pkg::coord_t     cx, cy, xn, yn, nx_in, ny_in;
    logic                 issue, loop_go, need_corners, ends_inside;
    logic signed [DW-1:0] nx2, ny2;
    logic [31:0]          addr_wide;

    assign xn = x_dec_reg ? x_reg - 1'b1 : x_reg + 1'b1;
    assign yn = y_dec_reg ? y_reg - 1'b1 : y_reg + 1'b1;
    assign nx2 = $signed(DW'({nx_reg, 1'b0}));
    assign ny2 = $signed(DW'({ny_reg, 1'b0}));
    assign loop_go = ((ix_reg < nx_reg) || (iy_reg < ny_reg)) && (guard_reg != '0);
    assign need_corners = (d_reg == '0) && !corner_cut;

    assign nx_in = (x_to >= x_from) ? x_to - x_from : x_from - x_to;
    assign ny_in = (y_to >= y_from) ? y_to - y_from : y_from - y_to;
    assign ends_inside =
        glos_pkg::coord_inside(x_from, grid_width, MAX_WIDTH) &&
        glos_pkg::coord_inside(y_from, grid_height, MAX_HEIGHT) &&
        glos_pkg::coord_inside(x_to, grid_width, MAX_WIDTH) &&
        glos_pkg::coord_inside(y_to, grid_height, MAX_HEIGHT);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        x_dec_next   = x_dec_reg;
        y_dec_next   = y_dec_reg;
        d_next       = d_reg;
        guard_next   = guard_reg;
        started_next = started_reg;
        sight_next   = sight_reg;
        cell_ok_next = cell_ok_reg;
        bit_sel_next = bit_sel_reg;
        cx           = x_reg;
        cy           = y_reg;
        issue        = 1'b0;

        case (state_reg)
            W_IDLE: begin
                if (ctl.start) begin
                    if (ends_inside) begin
                        x_next       = x_from;
                        y_next       = y_from;
                        nx_next      = nx_in;
                        ny_next      = ny_in;
                        ix_next      = '0;
                        iy_next      = '0;
                        x_dec_next   = x_to < x_from;
                        y_dec_next   = y_to < y_from;
                        d_next       = $signed(DW'(ny_in)) - $signed(DW'(nx_in));
                        guard_next   = GW'(nx_in) + GW'(ny_in);
                        phase_next   = PH_CORNER_A;
                        started_next = 1'b0;
                        state_next   = W_RUN;
                    end else begin
                        sight_next = 1'b0;
                        state_next = W_DONE;
                    end
                end
            end
            W_RUN: begin
                if (pend_reg && (!cell_ok_reg || rd_word[bit_sel_reg])) begin
                    sight_next = 1'b0;
                    state_next = W_DONE;
                end else if (!started_reg) begin
                    // start cell
                    issue        = 1'b1;
                    started_next = 1'b1;
                end else if (loop_go) begin
                    issue = 1'b1;
                    if (need_corners && phase_reg == PH_CORNER_A) begin
                        cy         = yn;
                        phase_next = PH_CORNER_B;
                    end else if (need_corners && phase_reg == PH_CORNER_B) begin
                        cx         = xn;
                        phase_next = PH_MOVE;
                    end else begin
                        phase_next = PH_CORNER_A;
                        guard_next = guard_reg - 1'b1;
                        if (d_reg == '0) begin
                            cx      = xn;
                            cy      = yn;
                            ix_next = ix_reg + 1'b1;
                            iy_next = iy_reg + 1'b1;
                            d_next  = d_reg + ny2 - nx2;
                        end else if (d_reg[DW-1]) begin
                            cx      = xn;
                            ix_next = ix_reg + 1'b1;
                            d_next  = d_reg + ny2;
                        end else begin
                            cy      = yn;
                            iy_next = iy_reg + 1'b1;
                            d_next  = d_reg - nx2;
                        end
                        x_next = cx;
                        y_next = cy;
                    end
                end else if (!pend_reg) begin
                    sight_next = 1'b1;
                    state_next = W_DONE;
                end
            end
            W_DONE: begin
                if (ctl.release_ack) begin
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase

        if (issue) begin
            cell_ok_next = glos_pkg::cell_in_row(cx, ROW_WORDS);
            bit_sel_next = cx[glos_pkg::BIT_SEL_W-1:0];
        end
        pend_next = issue;
    end

    assign addr_wide = glos_pkg::word_index(cx, cy, ROW_WORDS);
    assign rd_addr   = addr_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg   <= phase_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        ix_reg      <= ix_next;
        iy_reg      <= iy_next;
        x_dec_reg   <= x_dec_next;
        y_dec_reg   <= y_dec_next;
        d_reg       <= d_next;
        guard_reg   <= guard_next;
        started_reg <= started_next;
        cell_ok_reg <= cell_ok_next;
        bit_sel_reg <= bit_sel_next;
        sight_reg   <= sight_next;
    end

    assign stat.done  = (state_reg == W_DONE);
    assign stat.sight = sight_reg;

endmodule

### hw/rtl/grid_line_of_sight_check_unit.sv
// Line-of-sight checker over a blocked-cell bitmap of an occupancy grid.
// Input channel s_*: s_tuser is the command (0 write one cell, 1 query).
// A write sets or clears one cell's blocked bit and returns no item; a
// query returns one item on m_* whose bit 0 is 1 when the line between
// the two endpoints is clear. Endpoints outside the grid in use give 0.
// Config channel cfg_*: index 0 grid width, 1 grid height, 2 corner
// cutting enable; cfg_ready is always high, unknown indexes are dropped.
// A write is a read, modify and write back of one word.
// A query reads one bitmap cell per cycle from the single memory read port:
// start cell, one cell per straight step, three per diagonal step unless
// corner cutting is on. One item is worked at a time, with s_tready low.
// Reset loads the config registers with 256, 256 and 0 and then sweeps the
// bitmap to all walkable, one word per cycle over all MAX_HEIGHT * ROW_WORDS
// words (1024 by default), with s_tready low. Config writes are taken during the sweep.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a second query finishes its walk and
// then holds until the output register frees up.
module grid_line_of_sight_check_unit #(
    parameter int unsigned MAX_WIDTH  = glos_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = glos_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned ROW_WORDS  = glos_pkg::ROW_WORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [8:0] x_from, [17:9] y_from, [26:18] x_to, [35:27] y_to,
    // [36] cell_blocked, [39:37] zero
    input  logic [glos_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] command
    input  logic                                 s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] has_sight, [7:1] zero
    output logic [glos_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [glos_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [glos_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned DEPTH = MAX_HEIGHT * ROW_WORDS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = glos_pkg::COORD_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WR_RD = 3'd2;
    localparam logic [2:0] ST_WR_WB = 3'd3;
    localparam logic [2:0] ST_QUERY = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    glos_pkg::coord_t                grid_width_reg, grid_height_reg;
    logic                            corner_cut_reg;
    logic [AW-1:0]                   wr_addr_reg, wr_addr_next;
    logic [glos_pkg::BIT_SEL_W-1:0]  wr_bit_reg, wr_bit_next;
    logic                            wr_val_reg, wr_val_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            sight_out_reg, sight_out_next;

    glos_pkg::coord_t      in_x_from, in_y_from, in_x_to, in_y_to;
    logic                  in_blocked, in_accept, wr_ok;
    logic [31:0]           wr_addr_wide;
    glos_pkg::walk_ctl_t   walk_ctl;
    glos_pkg::walk_stat_t  walk_stat;
    logic [AW-1:0]         walk_addr, rd_addr, mem_wr_addr;
    logic                  mem_wr_en;
    glos_pkg::word_t       rd_word, word_mod, mem_wr_data;

    assign in_x_from  = s_tdata[CW-1:0];
    assign in_y_from  = s_tdata[2*CW-1:CW];
    assign in_x_to    = s_tdata[3*CW-1:2*CW];
    assign in_y_to    = s_tdata[4*CW-1:3*CW];
    assign in_blocked = s_tdata[4*CW];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // write target must be inside the grid in use and inside the stored row
    assign wr_ok = glos_pkg::coord_inside(in_x_from, grid_width_reg, MAX_WIDTH) &&
                   glos_pkg::coord_inside(in_y_from, grid_height_reg, MAX_HEIGHT) &&
                   glos_pkg::cell_in_row(in_x_from, ROW_WORDS);
    assign wr_addr_wide = glos_pkg::word_index(in_x_from, in_y_from, ROW_WORDS);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= glos_pkg::GRID_SIZE_RESET;
            grid_height_reg <= glos_pkg::GRID_SIZE_RESET;
            corner_cut_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                glos_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                glos_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                glos_pkg::REG_CORNER_CUT:  corner_cut_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wr_addr_next   = wr_addr_reg;
        wr_bit_next    = wr_bit_reg;
        wr_val_next    = wr_val_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        sight_out_next = sight_out_reg;
        walk_ctl       = '0;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == glos_pkg::CMD_QUERY) begin
                        walk_ctl.start = 1'b1;
                        state_next     = ST_QUERY;
                    end else if (wr_ok) begin
                        wr_addr_next = wr_addr_wide[AW-1:0];
                        wr_bit_next  = in_x_from[glos_pkg::BIT_SEL_W-1:0];
                        wr_val_next  = in_blocked;
                        state_next   = ST_WR_RD;
                    end
                end
            end
            ST_WR_RD: begin
                state_next = ST_WR_WB;
            end
            ST_WR_WB: begin
                state_next = ST_IDLE;
            end
            ST_QUERY: begin
                if (walk_stat.done && (!m_tvalid_reg || m_tready)) begin
                    walk_ctl.release_ack = 1'b1;
                    m_tvalid_next        = 1'b1;
                    sight_out_next       = walk_stat.sight;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg   <= wr_addr_next;
        wr_bit_reg    <= wr_bit_next;
        wr_val_reg    <= wr_val_next;
        sight_out_reg <= sight_out_next;
    end

    // read-modify-write of one word; the sweep writes zeros
    always_comb begin
        word_mod             = rd_word;
        word_mod[wr_bit_reg] = wr_val_reg;
    end

    assign mem_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WR_WB);
    assign mem_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wr_addr_reg;
    assign mem_wr_data = (state_reg == ST_CLEAR) ? '0 : word_mod;
    assign rd_addr     = (state_reg == ST_QUERY) ? walk_addr : wr_addr_reg;

    glos_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    glos_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_WORDS  (ROW_WORDS),
        .AW         (AW)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (walk_ctl),
        .x_from      (in_x_from),
        .y_from      (in_y_from),
        .x_to        (in_x_to),
        .y_to        (in_y_to),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .corner_cut  (corner_cut_reg),
        .rd_addr     (walk_addr),
        .rd_word     (rd_word),
        .stat        (walk_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(glos_pkg::OUT_DATA_W - 1)'(0), sight_out_reg};

endmodule
